// ----- src/pmgu_pkg.sv -----
package pmgu_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MASS = 2'd0;
  localparam logic [1:0] CFG_CX   = 2'd1;
  localparam logic [1:0] CFG_CY   = 2'd2;
  localparam logic [1:0] CFG_CZ   = 2'd3;

  localparam logic [31:0] MASS_RESET = 32'h0100_0000;

  // Square root: one result bit per stage.
  localparam int unsigned SQ_STEPS = 32;
  // Quotient bits kept by each divider; anything at or above 2^QW is an overflow.
  localparam int unsigned QW = 34;
  localparam int unsigned DIV_LAT = QW + 1;

  // Pipeline stage indexes, counted from the stage that holds the magnitudes.
  localparam int unsigned IDX_S   = 2;
  localparam int unsigned IDX_R   = IDX_S + SQ_STEPS + 1;
  localparam int unsigned IDX_R2  = IDX_R + 1;
  localparam int unsigned IDX_R3P = IDX_R2 + 1;
  localparam int unsigned IDX_DIN = IDX_R3P + 1;
  localparam int unsigned PL      = IDX_DIN + DIV_LAT + 1;

  // Numerator width of the acceleration term: 63-bit product shifted by up to 40.
  localparam int unsigned NA_W = 103;
  localparam int unsigned DA_W = 96;
  localparam int unsigned NP_W = 48;
  localparam int unsigned DP_W = 33;

  // Side data that travels with each item through the whole pipeline.
  typedef struct packed {
    logic [2:0][31:0] acc;
    logic [31:0]      pot;
    logic [2:0]       neg;
    logic             zero;
    logic             k;
  } pay_t;

  // One finished result.
  typedef struct packed {
    logic [3:0][31:0] val;
    logic             zero;
    logic             sat;
  } res_t;

endpackage

// ----- src/pmgu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags quotients of 2^QW or more; the remaining stages produce the low QW
// quotient bits, which are only meaningful when no overflow was flagged.
module pmgu_div #(
  parameter int unsigned NW = pmgu_pkg::NA_W,
  parameter int unsigned DW = pmgu_pkg::DA_W,
  parameter int unsigned QW = pmgu_pkg::QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic          ovf_q [QW+1];
  logic [QW-1:0] quo_q [1:QW];

  logic [CW-1:0] hi_w;
  logic [CW-1:0] den_w;

  // Overflow test: the quotient reaches 2^QW when num >> QW is at least den.
  assign hi_w  = CW'(num_i[NW-1:QW]);
  assign den_w = CW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (hi_w >= den_w);
      rem_q[0] <= hi_w[DW-1:0];
      low_q[0] <= num_i[QW-1:0];
      den_q[0] <= den_i;
    end
  end

  // One quotient bit per stage.
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [QW-1:0] quo_in;

    if (j == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[j];
    end

    always_comb begin
      trial = {rem_q[j], low_q[j][QW-1]};
      diff  = trial - {1'b0, den_q[j]};
      ge    = (trial >= {1'b0, den_q[j]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= {quo_in[QW-2:0], ge};
        ovf_q[j+1] <= ovf_q[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          low_q[j+1] <= {low_q[j][QW-2:0], 1'b0};
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ----- src/point_mass_gravity_update.sv -----
// Point-mass gravity update. Each transfer on the slave stream carries one
// particle (position in Q8.24, accumulated acceleration and potential in
// Q16.16); the master stream returns acceleration - m*r/|r|^3 and
// potential - m/|r|, clipped to 32 bits with a saturation flag, or the
// inputs unchanged with a zero-distance flag when the particle sits on the
// center. The block takes one particle every clock cycle while its output
// buffer has room. The stages compute the offset and its magnitudes, the
// squared length, the bit-per-stage square root, the powers of the length
// and the numerators, the bit-per-stage dividers and the final subtraction,
// followed by a two-entry output buffer. Downstream stalls freeze the
// pipeline only once that buffer is full. Configuration writes take effect
// at once and are meant for idle periods.
module point_mass_gravity_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0 up: pos_x, pos_y, pos_z, acc_in_x, acc_in_y,
  // acc_in_z, pot_in.
  input  logic [223:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: acc_out_x, acc_out_y, acc_out_z, pot_out.
  output logic [127:0] m_axis_tdata,
  // Fields from bit 0 up: saturated, zero_distance.
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned PL  = pmgu_pkg::PL;
  localparam int unsigned SQN = pmgu_pkg::SQ_STEPS;
  localparam int unsigned QW  = pmgu_pkg::QW;

  // Configuration registers.
  logic [31:0] mass_q;
  logic [2:0][31:0] ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= pmgu_pkg::MASS_RESET;
      ctr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmgu_pkg::CFG_MASS: mass_q   <= cfg_wdata_i;
        pmgu_pkg::CFG_CX:   ctr_q[0] <= cfg_wdata_i;
        pmgu_pkg::CFG_CY:   ctr_q[1] <= cfg_wdata_i;
        pmgu_pkg::CFG_CZ:   ctr_q[2] <= cfg_wdata_i;
        default:            mass_q   <= mass_q;
      endcase
    end
  end

  // Pipeline enable: everything moves while the output buffer has room.
  logic [1:0] cnt_q;
  logic       en;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // Stage 1: offsets from the center.
  logic                v1_q;
  logic signed [32:0]  d1_q [3];
  logic [2:0][31:0]    acc1_q;
  logic [31:0]         pot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]})
                 - $signed({ctr_q[i][31], ctr_q[i]});
        acc1_q[i] <= s_axis_tdata[96+32*i +: 32];
      end
      pot1_q <= s_axis_tdata[192 +: 32];
    end
  end

  // Valid bits and side data for the long pipeline.
  logic [PL-1:0]       vld_q;
  pmgu_pkg::pay_t      pay_q [PL];
  logic [2:0][30:0]    e_q [pmgu_pkg::IDX_R2];

  // Stage index 0: magnitudes, block scale and zero test.
  logic [32:0]      mag [3];
  logic             kk;
  logic [2:0][30:0] e_n;
  pmgu_pkg::pay_t   pay_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
    end
    kk = mag[0][31] | mag[1][31] | mag[2][31];
    for (int i = 0; i < 3; i++) begin
      e_n[i] = kk ? mag[i][31:1] : mag[i][30:0];
    end
    pay_n.acc  = acc1_q;
    pay_n.pot  = pot1_q;
    pay_n.neg  = {d1_q[2][32], d1_q[1][32], d1_q[0][32]};
    pay_n.zero = (d1_q[0] == '0) && (d1_q[1] == '0) && (d1_q[2] == '0);
    pay_n.k    = kk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PL-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= pay_n;
      e_q[0]   <= e_n;
      for (int j = 1; j < PL; j++) begin
        pay_q[j] <= pay_q[j-1];
      end
      for (int j = 1; j < pmgu_pkg::IDX_R2; j++) begin
        e_q[j] <= e_q[j-1];
      end
    end
  end

  // Stages 1 and 2: squares and their sum.
  logic [61:0] sq_q [3];
  logic [63:0] sqs_q [SQN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 62'(e_q[0][i]) * 62'(e_q[0][i]);
      end
      sqs_q[0] <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    end
  end

  // Square root, one result bit per stage.
  logic [33:0] rem_q  [1:SQN];
  logic [31:0] root_q [1:SQN];

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rt;
    logic [35:0] tr;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j];
      assign root_in = root_q[j];
    end

    always_comb begin
      rt = {rem_in, sqs_q[j][63:62]};
      tr = {2'b00, root_in, 2'b01};
      ge = (rt >= tr);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j+1]  <= ge ? 34'(rt - tr) : rt[33:0];
        root_q[j+1] <= {root_in[30:0], ge};
      end
    end

    if (j < SQN - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en) begin
          sqs_q[j+1] <= {sqs_q[j][61:0], 2'b00};
        end
      end
    end
  end

  // Rounding of the root, powers of the length and the numerators.
  logic [31:0]      r_q;
  logic [31:0]      r36_q;
  logic [31:0]      r37_q;
  logic [63:0]      r2_q;
  logic [62:0]      ma36_q [3];
  logic [62:0]      ma37_q [3];
  logic [63:0]      r3lo_q;
  logic [63:0]      r3hi_q;
  logic [pmgu_pkg::NA_W-1:0] na_q [3];
  logic [pmgu_pkg::DA_W-1:0] da_q;
  logic [pmgu_pkg::NP_W-1:0] np_q;
  logic [pmgu_pkg::DP_W-1:0] dp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= root_q[SQN] + 32'((34'(root_q[SQN]) < rem_q[SQN]) ? 1 : 0);
      r36_q <= r_q;
      r2_q  <= 64'(r_q) * 64'(r_q);
      for (int i = 0; i < 3; i++) begin
        ma36_q[i] <= 63'(mass_q) * 63'(e_q[pmgu_pkg::IDX_R2-1][i]);
        ma37_q[i] <= ma36_q[i];
        na_q[i]   <= pay_q[pmgu_pkg::IDX_R3P].k
                   ? (pmgu_pkg::NA_W'(ma37_q[i]) << 38)
                   : (pmgu_pkg::NA_W'(ma37_q[i]) << 40);
      end
      r37_q  <= r36_q;
      r3lo_q <= 64'(r2_q[31:0]) * 64'(r36_q);
      r3hi_q <= 64'(r2_q[63:32]) * 64'(r36_q);
      da_q   <= pmgu_pkg::DA_W'(r3lo_q) + {r3hi_q, 32'd0};
      np_q   <= {mass_q, 16'd0};
      dp_q   <= pay_q[pmgu_pkg::IDX_R3P].k ? {r37_q, 1'b0} : {1'b0, r37_q};
    end
  end

  // Dividers: three acceleration terms and the potential.
  logic [QW-1:0] qa [3];
  logic          oa [3];
  logic [QW-1:0] qp;
  logic          op;

  for (genvar i = 0; i < 3; i++) begin : g_diva
    pmgu_div #(
      .NW(pmgu_pkg::NA_W),
      .DW(pmgu_pkg::DA_W),
      .QW(QW)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(na_q[i]),
      .den_i(da_q),
      .quo_o(qa[i]),
      .ovf_o(oa[i])
    );
  end

  pmgu_div #(
    .NW(pmgu_pkg::NP_W),
    .DW(pmgu_pkg::DP_W),
    .QW(QW)
  ) u_divp (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(np_q),
    .den_i(dp_q),
    .quo_o(qp),
    .ovf_o(op)
  );

  // Terms above 2^33 are held at 2^33.
  function automatic logic [QW-1:0] cap_term(input logic ovf, input logic [QW-1:0] q);
    logic big;
    big = ovf || (q[QW-1] && (q[QW-2:0] != '0));
    return big ? {1'b1, {(QW-1){1'b0}}} : q;
  endfunction

  // Subtract one term from a running value, or add it when add is set, with clipping to 32 bits.
  function automatic logic [32:0] sat_sub(input logic [31:0] v, input logic [QW-1:0] t,
                                          input logic add);
    logic signed [QW+1:0] s;
    logic [32:0] r;
    s = add ? ($signed((QW+2)'($signed(v))) + $signed({2'b00, t}))
            : ($signed((QW+2)'($signed(v))) - $signed({2'b00, t}));
    if (s > $signed((QW+2)'(32'sh7FFF_FFFF))) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (s < $signed((QW+2)'(-33'sd2147483648))) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

  // Final subtraction and pass-through at zero distance.
  pmgu_pkg::pay_t pl;
  pmgu_pkg::res_t res_n;
  logic [32:0]    sr [4];

  always_comb begin
    pl = pay_q[PL-1];
    for (int i = 0; i < 3; i++) begin
      sr[i] = sat_sub(pl.acc[i], cap_term(oa[i], qa[i]), pl.neg[i]);
    end
    sr[3] = sat_sub(pl.pot, cap_term(op, qp), 1'b0);
    if (pl.zero) begin
      res_n.val  = {pl.pot, pl.acc[2], pl.acc[1], pl.acc[0]};
      res_n.sat  = 1'b0;
      res_n.zero = 1'b1;
    end else begin
      res_n.val  = {sr[3][31:0], sr[2][31:0], sr[1][31:0], sr[0][31:0]};
      res_n.sat  = sr[0][32] | sr[1][32] | sr[2][32] | sr[3][32];
      res_n.zero = 1'b0;
    end
  end

  // Two-entry output buffer.
  pmgu_pkg::res_t ent_q [2];
  logic           push;
  logic           pop;

  assign push = en && vld_q[PL-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !push) begin
      ent_q[0] <= ent_q[1];
    end else if (push && !pop) begin
      ent_q[cnt_q[0]] <= res_n;
    end else if (push && pop) begin
      ent_q[0] <= res_n;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ent_q[0].val;
  assign m_axis_tuser  = {ent_q[0].zero, ent_q[0].sat};

  // The buffer never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer overflow");

  // An accepted input enters the first stage on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted item not captured");

  // A frozen pipeline keeps every valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(v1_q))
    else $error("pipeline moved while stalled");

  // A pass-through result never reports clipping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("zero-distance result flagged as saturated");

endmodule

// ----- sim/point_mass_gravity_update_test.sv -----
module point_mass_gravity_update_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TERM_LIMIT = 64'd1 << 33;

  // One particle as it enters the block.
  typedef struct packed {
    logic [31:0] pot;
    logic [2:0][31:0] acc;
    logic [2:0][31:0] pos;
  } particle_t;

  // Gravity predictor and the queue of results it expects.
  class gravity_scoreboard;
    logic [31:0] mass;
    logic [2:0][31:0] center;
    pmgu_pkg::res_t pending_q[$];
    int errors;

    function new();
      mass = pmgu_pkg::MASS_RESET;
      center = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        pmgu_pkg::CFG_MASS: mass = val;
        pmgu_pkg::CFG_CX:   center[0] = val;
        pmgu_pkg::CFG_CY:   center[1] = val;
        default:            center[2] = val;
      endcase
    endfunction

    // Integer square root rounded to nearest.
    function longint unsigned length_of(longint unsigned sq);
      longint unsigned root, bitv, rem;
      root = 0;
      rem = sq;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (rem > root) root++;
      return root;
    endfunction

    function longint clip32(longint v, inout logic sat);
      if (v > 64'sh7FFF_FFFF) begin
        sat = 1'b1;
        return 64'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        sat = 1'b1;
        return -64'sh8000_0000;
      end
      return v;
    endfunction

    // Work out the result of an accepted particle.
    function void note_particle(particle_t p);
      longint offs[3];
      longint unsigned mag[3];
      longint unsigned sq, len, pterm;
      logic [127:0] num, den, aterm;
      logic scale;
      pmgu_pkg::res_t r;
      scale = 1'b0;
      r = '0;
      for (int i = 0; i < 3; i++) begin
        offs[i] = longint'($signed(p.pos[i])) - longint'($signed(center[i]));
        if (offs[i] >= 64'sd2147483648 || offs[i] <= -64'sd2147483648) scale = 1'b1;
      end
      if (offs[0] == 0 && offs[1] == 0 && offs[2] == 0) begin
        for (int i = 0; i < 3; i++) r.val[i] = p.acc[i];
        r.val[3] = p.pot;
        r.zero = 1'b1;
      end else begin
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (offs[i] < 0) ? longint'(-offs[i]) : longint'(offs[i]);
          mag[i] = mag[i] >> scale;
          sq += mag[i] * mag[i];
        end
        len = length_of(sq);
        pterm = ({32'd0, mass} << 16) / (len << scale);
        if (pterm > TERM_LIMIT) pterm = TERM_LIMIT;
        r.val[3] = 32'(clip32(longint'($signed(p.pot)) - longint'(pterm), r.sat));
        den = 128'(len) * 128'(len) * 128'(len);
        for (int i = 0; i < 3; i++) begin
          num = (128'(mass) * 128'(mag[i])) << (40 - 2 * scale);
          aterm = num / den;
          if (aterm > 128'(TERM_LIMIT)) aterm = 128'(TERM_LIMIT);
          if (offs[i] < 0)
            r.val[i] = 32'(clip32(longint'($signed(p.acc[i])) + longint'(aterm), r.sat));
          else
            r.val[i] = 32'(clip32(longint'($signed(p.acc[i])) - longint'(aterm), r.sat));
        end
      end
      pending_q = {pending_q, r};
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation.
    task check_result(logic [127:0] data, logic [1:0] flags);
      pmgu_pkg::res_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h flags %b", data, flags));
        return;
      end
      want = pending_q.pop_front();
      for (int i = 0; i < 4; i++)
        if (data[32*i +: 32] !== want.val[i])
          report($sformatf("value %0d got %h want %h", i, data[32*i +: 32], want.val[i]));
      if (flags[0] !== want.sat)
        report($sformatf("saturated got %b want %b", flags[0], want.sat));
      if (flags[1] !== want.zero)
        report($sformatf("zero_distance got %b want %b", flags[1], want.zero));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [223:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = pmgu_pkg::CFG_MASS;
  logic [31:0] cfg_wdata_i = '0;

  gravity_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;

  point_mass_gravity_update DUT (.*);

  always #4 clk_i = ~clk_i;

  // Watch both streams for completed transfers.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.note_particle(particle_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request && held < 300) begin
        held++;
        m_axis_tready <= 1'b0;
      end else begin
        if (!hold_request) held = 0;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one particle and hold it until the block takes it.
  task send_particle(particle_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= p;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending, let the last transfer be noted and wait for every result.
  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    board.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task set_center(logic [31:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    drain();
    write_reg(pmgu_pkg::CFG_MASS, m);
    write_reg(pmgu_pkg::CFG_CX, x);
    write_reg(pmgu_pkg::CFG_CY, y);
    write_reg(pmgu_pkg::CFG_CZ, z);
  endtask

  // Random particle: mostly near the center, sometimes on it or anywhere.
  function particle_t random_particle();
    particle_t p;
    int kind, span;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      p.acc[i] = ($urandom_range(0, 7) == 0) ? {$urandom_range(0, 1) == 1, {31{1'b0}}} ^
                 {1'b0, {31{$urandom_range(0, 1) == 1}}} : $urandom;
      span = $urandom_range(4, 31);
      case (kind)
        0: p.pos[i] = board.center[i];
        1, 2: p.pos[i] = $urandom;
        default: p.pos[i] = board.center[i] + ($urandom & ((32'd1 << span) - 1)) -
                            (32'd1 << (span - 1));
      endcase
    end
    p.pot = ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom;
    return p;
  endfunction

  function particle_t make_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    logic [31:0] acc, logic [31:0] pot);
    particle_t p;
    p.pos[0] = x;
    p.pos[1] = y;
    p.pos[2] = z;
    p.acc = {3{acc}};
    p.pot = pot;
    return p;
  endfunction

  task random_phase(int count);
    for (int n = 0; n < count; n++) send_particle(random_particle());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed particles with the reset settings.
    send_idle_pct = 15;
    recv_idle_pct = 62;
    send_particle(make_particle(0, 0, 0, 32'h1234_5678, 32'h8765_4321));
    send_particle(make_particle(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_particle(make_particle(32'h0100_0000, 0, 0, 0, 0));
    send_particle(make_particle(0, 32'hFF00_0000, 0, 32'h0001_0000, 32'h0001_0000));
    send_particle(make_particle(1, 0, 0, 0, 0));
    send_particle(make_particle(0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000));
    send_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000));
    send_particle(make_particle(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
    send_particle(make_particle(32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800,
                                32'h7FFF_0000, 32'h8000_FFFF));
    send_particle(make_particle(32'h0300_0000, 32'h0400_0000, 0, 32'hAAAA_AAAA,
                                32'h5555_5555));
    random_phase(70);

    // Maximum mass, center at one extreme; particles far, on and beside it.
    set_center(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_idle_pct = 62;
    recv_idle_pct = 15;
    send_particle(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    send_particle(make_particle(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    random_phase(70);

    // Zero mass: the particle comes back unchanged.
    set_center(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40);
    while (board.pending_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    random_phase(40);

    // Random settings, with a long receiver hold-off to fill the pipeline.
    set_center($urandom, $urandom, $urandom, $urandom);
    hold_request = 1'b1;
    random_phase(120);
    hold_request = 1'b0;
    set_center($urandom_range(1, 32'h0400_0000), $urandom, $urandom, $urandom);
    random_phase(50);

    drain();
    if (board.errors == 0) begin
      $display("point_mass_gravity_update verification clean");
    end else begin
      $display("point_mass_gravity_update verification failed");
    end
    $finish;
  end

  // Stop a run that hangs.
  initial begin
    #4ms;
    $display("point_mass_gravity_update verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pmgu_pkg.sv
src/pmgu_div.sv
src/point_mass_gravity_update.sv
sim/point_mass_gravity_update_test.sv
